/* design/hsv_to_rgb444_converter_core_macros.svh */
// ---------------------------------------------------------------------------
// hsv to rgb444 converter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB444_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB444_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define HSV2RGB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv2rgb assertion failed");

// next-cycle implication
`define HSV2RGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv2rgb assertion failed");

`endif

/* design/hsv2rgb_pkg.sv */
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// types, constants and helper functions of the hsv to rgb444 converter
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int unsigned REGION_SIZE = 43;
    localparam int unsigned REM_SCALE   = 6;

    typedef logic [7:0]  hue_t;
    typedef logic [7:0]  chan_t;
    typedef logic [3:0]  nib_t;
    typedef logic [11:0] rgb_t;
    typedef logic [1:0]  cfg_index_t;
    typedef logic [7:0]  cfg_data_t;

    localparam chan_t FULL8 = 8'hFF;

    localparam cfg_index_t CFG_SATURATION = 2'd0;
    localparam cfg_index_t CFG_BRIGHTNESS = 2'd1;

    typedef enum logic [2:0] {
        SECT_RED_YEL,
        SECT_YEL_GRN,
        SECT_GRN_CYN,
        SECT_CYN_BLU,
        SECT_BLU_MAG,
        SECT_MAG_RED
    } sect_t;

    typedef struct packed {
        sect_t sect;
        chan_t rem;
    } split_t;

    // region of the hue circle and remainder scaled by six
    function automatic split_t hue_split(hue_t h);
        split_t res;
        hue_t   base;
        logic [5:0] diff;
        if (h >= 8'(5 * REGION_SIZE)) begin
            res.sect = SECT_MAG_RED;
            base     = 8'(5 * REGION_SIZE);
        end else if (h >= 8'(4 * REGION_SIZE)) begin
            res.sect = SECT_BLU_MAG;
            base     = 8'(4 * REGION_SIZE);
        end else if (h >= 8'(3 * REGION_SIZE)) begin
            res.sect = SECT_CYN_BLU;
            base     = 8'(3 * REGION_SIZE);
        end else if (h >= 8'(2 * REGION_SIZE)) begin
            res.sect = SECT_GRN_CYN;
            base     = 8'(2 * REGION_SIZE);
        end else if (h >= 8'(REGION_SIZE)) begin
            res.sect = SECT_YEL_GRN;
            base     = 8'(REGION_SIZE);
        end else begin
            res.sect = SECT_RED_YEL;
            base     = 8'd0;
        end
        diff    = 6'(h - base);
        res.rem = 8'({2'b00, diff} * 8'(REM_SCALE));
        return res;
    endfunction

    // upper byte of an 8x8 product
    function automatic chan_t mul_hi(chan_t a, chan_t b);
        logic [15:0] prod;
        prod = {8'h00, a} * {8'h00, b};
        return prod[15:8];
    endfunction

    function automatic nib_t nib(chan_t v);
        return v[7:4];
    endfunction

endpackage

/* design/hsv2rgb_hue_if.sv */
// ---------------------------------------------------------------------------
// hsv2rgb_hue_if
// valid/ready channel carrying one hue word
// ---------------------------------------------------------------------------
interface hsv2rgb_hue_if;
    logic              valid;
    logic              ready;
    hsv2rgb_pkg::hue_t hue;

    modport source (output valid, output hue, input ready);
    modport sink   (input valid, input hue, output ready);
endinterface

/* design/hsv2rgb_rgb_if.sv */
// ---------------------------------------------------------------------------
// hsv2rgb_rgb_if
// valid/ready channel carrying one packed rgb444 word
// ---------------------------------------------------------------------------
interface hsv2rgb_rgb_if;
    logic              valid;
    logic              ready;
    hsv2rgb_pkg::rgb_t rgb_color;

    modport source (output valid, output rgb_color, input ready);
    modport sink   (input valid, input rgb_color, output ready);
endinterface

/* design/hsv2rgb_cfg_if.sv */
// ---------------------------------------------------------------------------
// hsv2rgb_cfg_if
// register write channel: index and data word
// ---------------------------------------------------------------------------
interface hsv2rgb_cfg_if;
    logic                    valid;
    logic                    ready;
    hsv2rgb_pkg::cfg_index_t index;
    hsv2rgb_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/hsv_to_rgb444_converter_core.sv */
// ---------------------------------------------------------------------------
// hsv_to_rgb444_converter_core
// converts a stream of 8-bit hues into packed 12-bit rgb444 colors
// ---------------------------------------------------------------------------
// Takes one hue word per clock while the output is not stalled and returns
// one rgb444 word per hue, in order, after the register stages. Saturation
// (register 0) and brightness (register 1) both reset to 255 and apply to
// every conversion; write them only while no word is in flight. The four
// register stages are hue split, the three first 8x8 multiplies, the second
// pair of multiplies, and channel select into the output register; each
// stage has its own valid bit and moves on when the one after it is free, so
// a stall at the output backs up one stage at a time and bubbles are squeezed
// out. Saturation zero gives a grey built from the brightness top nibble.
// Register indexes other than 0 and 1 are ignored.
module hsv_to_rgb444_converter_core (
    input  logic          clk,
    input  logic          rst_n,
    hsv2rgb_hue_if.sink   hue_stream,
    hsv2rgb_rgb_if.source color_stream,
    hsv2rgb_cfg_if.sink   cfg
);
    import hsv2rgb_pkg::*;

    `include "hsv_to_rgb444_converter_core_macros.svh"

    chan_t sat_reg, sat_next;
    chan_t bri_reg, bri_next;

    logic en1, en2, en3, en4;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic rgb_valid_reg, rgb_valid_next;

    split_t s1_split_reg;
    logic   s1_grey_reg;

    sect_t  s2_sect_reg;
    logic   s2_grey_reg;
    chan_t  s2_p_reg, s2_sa_reg, s2_sb_reg;

    sect_t  s3_sect_reg;
    logic   s3_grey_reg;
    chan_t  s3_p_reg, s3_q_reg, s3_t_reg;

    rgb_t   rgb_reg, rgb_next;
    nib_t   vn, pn, qn, tn;

    // configuration
    assign cfg.ready = 1'b1;

    always_comb
    begin
        sat_next = sat_reg;
        bri_next = bri_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SATURATION: sat_next = cfg.data;
                CFG_BRIGHTNESS: bri_next = cfg.data;
                default:        ;
            endcase
        end
    end

    // stage enables
    assign en4 = !rgb_valid_reg || color_stream.ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign hue_stream.ready = en1;

    assign s1_valid_next  = en1 ? hue_stream.valid : s1_valid_reg;
    assign s2_valid_next  = en2 ? s1_valid_reg     : s2_valid_reg;
    assign s3_valid_next  = en3 ? s2_valid_reg     : s3_valid_reg;
    assign rgb_valid_next = en4 ? s3_valid_reg     : rgb_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg       <= FULL8;
            bri_reg       <= FULL8;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end
        else
        begin
            sat_reg       <= sat_next;
            bri_reg       <= bri_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            rgb_valid_reg <= rgb_valid_next;
        end
    end

    // channel select
    assign vn = nib(bri_reg);
    assign pn = nib(s3_p_reg);
    assign qn = nib(s3_q_reg);
    assign tn = nib(s3_t_reg);

    always_comb
    begin
        if (s3_grey_reg)
        begin
            rgb_next = {vn, vn, vn};
        end
        else
        begin
            unique case (s3_sect_reg)
                SECT_RED_YEL: rgb_next = {vn, tn, pn};
                SECT_YEL_GRN: rgb_next = {qn, vn, pn};
                SECT_GRN_CYN: rgb_next = {pn, vn, tn};
                SECT_CYN_BLU: rgb_next = {pn, qn, vn};
                SECT_BLU_MAG: rgb_next = {tn, pn, vn};
                default:      rgb_next = {vn, pn, qn};
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en1 && hue_stream.valid)
        begin
            s1_split_reg <= hue_split(hue_stream.hue);
            s1_grey_reg  <= (sat_reg == 8'd0);
        end
        if (en2 && s1_valid_reg)
        begin
            s2_sect_reg <= s1_split_reg.sect;
            s2_grey_reg <= s1_grey_reg;
            s2_p_reg    <= mul_hi(bri_reg, FULL8 - sat_reg);
            s2_sa_reg   <= mul_hi(sat_reg, s1_split_reg.rem);
            s2_sb_reg   <= mul_hi(sat_reg, FULL8 - s1_split_reg.rem);
        end
        if (en3 && s2_valid_reg)
        begin
            s3_sect_reg <= s2_sect_reg;
            s3_grey_reg <= s2_grey_reg;
            s3_p_reg    <= s2_p_reg;
            s3_q_reg    <= mul_hi(bri_reg, FULL8 - s2_sa_reg);
            s3_t_reg    <= mul_hi(bri_reg, FULL8 - s2_sb_reg);
        end
        if (en4 && s3_valid_reg)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign color_stream.valid     = rgb_valid_reg;
    assign color_stream.rgb_color = rgb_reg;

    `HSV2RGB_ASSERT_NEXT(a_accept_fills_s1, hue_stream.valid && hue_stream.ready, s1_valid_reg)
    `HSV2RGB_ASSERT_NEXT(a_s3_reaches_out, en4 && s3_valid_reg, rgb_valid_reg)
    `HSV2RGB_ASSERT_NEXT(a_grey_channels, en4 && s3_valid_reg && s3_grey_reg, rgb_reg[11:8] == rgb_reg[7:4] && rgb_reg[7:4] == rgb_reg[3:0])
    `HSV2RGB_ASSERT_NOW(a_rem_range, s1_valid_reg, s1_split_reg.rem <= 8'd252)

endmodule
